@@ rtl/ftc_pkg.sv @@
// Shared types, codes and character mapping helpers for the FRU field text codec.
`timescale 1ns / 1ps
`default_nettype none
package ftc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DIRECTION  = 2'd0;
  localparam logic [1:0] CFG_FIELD_TYPE = 2'd1;

  // Direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Field type codes (the spare code behaves as raw copy)
  localparam logic [1:0] FT_RAW = 2'd0;
  localparam logic [1:0] FT_BCD = 2'd1;
  localparam logic [1:0] FT_SIX = 2'd2;

  // BCD plus special nibbles
  localparam logic [3:0] BCD_SPACE = 4'hA;
  localparam logic [3:0] BCD_DASH  = 4'hB;
  localparam logic [3:0] BCD_DOT   = 4'hC;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // Packing position and partial bits carried between requests
  typedef struct packed {
    logic [1:0] phase;
    logic [5:0] held;
  } codec_state_t;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  // What one request produces
  typedef struct packed {
    logic [1:0]   count;
    logic [7:0]   res0;
    logic [7:0]   res1;
    codec_state_t state_nxt;
  } step_out_t;

  // Character to BCD plus nibble
  function automatic logic [3:0] bcd_code(input logic [7:0] ch);
    logic [7:0] diff;
    begin
      diff = ch - CH_ZERO;
      if (ch == CH_NUL || ch == CH_SPACE) bcd_code = BCD_SPACE;
      else if (ch == CH_DASH)             bcd_code = BCD_DASH;
      else if (ch == CH_DOT)              bcd_code = BCD_DOT;
      else                                bcd_code = diff[3:0];
    end
  endfunction

  // BCD plus nibble to character
  function automatic logic [7:0] bcd_char(input logic [3:0] n);
    begin
      if (n == BCD_SPACE)     bcd_char = CH_SPACE;
      else if (n == BCD_DASH) bcd_char = CH_DASH;
      else if (n == BCD_DOT)  bcd_char = CH_DOT;
      else                    bcd_char = CH_ZERO + {4'h0, n};
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/ftc_step.sv @@
// Combinational codec step: one request against the packing state gives up to two results.
`timescale 1ns / 1ps
`default_nettype none
module ftc_step (
  input  wire logic                  direction,
  input  wire logic [1:0]            field_type,
  input  wire ftc_pkg::codec_state_t state,
  input  wire logic [7:0]            in_data,
  input  wire logic                  in_flag_last,
  output ftc_pkg::step_out_t         step
);

  logic [3:0] nib;
  logic [5:0] six;
  logic [7:0] six_wide;

  // 6-bit code of a character, offset from space
  assign six_wide = in_data - ftc_pkg::CH_SPACE;
  assign six      = six_wide[5:0];
  assign nib      = ftc_pkg::bcd_code(in_data);

  always_comb begin
    step           = '0;
    step.state_nxt = state;
    case (field_type)
      ftc_pkg::FT_BCD: begin
        if (direction == ftc_pkg::DIR_ENCODE) begin
          if (state.phase == 2'd0) begin
            step.state_nxt.held  = {2'b00, nib};
            step.state_nxt.phase = 2'd1;
            // Odd length: pad with a space
            if (in_flag_last) begin
              step.count = 2'd1;
              step.res0  = {nib, ftc_pkg::BCD_SPACE};
            end
          end else begin
            step.count           = 2'd1;
            step.res0            = {state.held[3:0], nib};
            step.state_nxt.phase = 2'd0;
          end
        end else begin
          step.count = 2'd2;
          step.res0  = ftc_pkg::bcd_char(in_data[7:4]);
          step.res1  = ftc_pkg::bcd_char(in_data[3:0]);
        end
      end
      ftc_pkg::FT_SIX: begin
        if (direction == ftc_pkg::DIR_ENCODE) begin
          case (state.phase)
            2'd0: begin
              step.state_nxt.held  = six;
              step.state_nxt.phase = 2'd1;
              if (in_flag_last) begin
                step.count = 2'd1;
                step.res0  = {2'b00, six};
              end
            end
            2'd1: begin
              step.res0            = {six[1:0], state.held};
              step.state_nxt.held  = {2'b00, six[5:2]};
              step.state_nxt.phase = 2'd2;
              step.count           = in_flag_last ? 2'd2 : 2'd1;
              step.res1            = {4'h0, six[5:2]};
            end
            2'd2: begin
              step.res0            = {six[3:0], state.held[3:0]};
              step.state_nxt.held  = {4'h0, six[5:4]};
              step.state_nxt.phase = 2'd3;
              step.count           = in_flag_last ? 2'd2 : 2'd1;
              step.res1            = {6'h00, six[5:4]};
            end
            default: begin
              step.res0            = {six, state.held[1:0]};
              step.state_nxt.held  = '0;
              step.state_nxt.phase = 2'd0;
              step.count           = 2'd1;
            end
          endcase
        end else begin
          case (state.phase)
            2'd0: begin
              step.count           = 2'd1;
              step.res0            = {2'b00, in_data[5:0]} + ftc_pkg::CH_SPACE;
              step.state_nxt.held  = {4'h0, in_data[7:6]};
              step.state_nxt.phase = 2'd1;
            end
            2'd1: begin
              step.count           = 2'd1;
              step.res0 = {2'b00, in_data[3:0], state.held[1:0]} + ftc_pkg::CH_SPACE;
              step.state_nxt.held  = {2'b00, in_data[7:4]};
              step.state_nxt.phase = 2'd2;
            end
            default: begin
              step.count           = 2'd2;
              step.res0 = {2'b00, in_data[1:0], state.held[3:0]} + ftc_pkg::CH_SPACE;
              step.res1            = {2'b00, in_data[7:2]} + ftc_pkg::CH_SPACE;
              step.state_nxt.held  = '0;
              step.state_nxt.phase = 2'd0;
            end
          endcase
        end
      end
      default: begin
        step.count = 2'd1;
        step.res0  = in_data;
      end
    endcase
    // End of field: drop any partial group
    if (in_flag_last) begin
      step.state_nxt = '0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/fru_field_text_codec.sv @@
// Top level of the FRU field text codec: input register, codec step and result queue.
// A request goes into the input register, then through the step into the result queue.
// Throughput: one request per cycle while each gives at most one result and out_ready
// is high; two-result requests are limited by the single result port draining the queue.
// Reset (synchronous, rst_n low) clears configuration, packing state and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module fru_field_text_codec (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_data,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] out_byte,
  output      logic       out_last
);

  logic                  direction_r;
  logic [1:0]            field_type_r;
  ftc_pkg::codec_state_t state_r;

  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic                  s1_last_r;

  ftc_pkg::result_t      queue_r [4];
  logic [1:0]            wr_ptr_r;
  logic [1:0]            rd_ptr_r;
  logic [2:0]            count_r;

  ftc_pkg::step_out_t    step;
  logic                  pop;
  logic [2:0]            after_pop;
  logic                  room;
  logic                  advance;
  logic                  cfg_hit;

  // Codec step on the registered request
  ftc_step u_step (
    .direction    (direction_r),
    .field_type   (field_type_r),
    .state        (state_r),
    .in_data      (s1_byte_r),
    .in_flag_last (s1_last_r),
    .step         (step)
  );

  // Queue handshake: advance only with room for two results
  assign pop       = out_valid & out_ready;
  assign after_pop = count_r - {2'b00, pop};
  assign room      = (after_pop <= 3'd2);
  assign advance   = s1_valid_r & room;
  assign in_ready  = ~s1_valid_r | room;
  assign cfg_hit   = cfg_we &
                     (cfg_index == ftc_pkg::CFG_DIRECTION ||
                      cfg_index == ftc_pkg::CFG_FIELD_TYPE);

  assign out_valid = (count_r != 3'd0);
  assign out_byte  = queue_r[rd_ptr_r].data;
  assign out_last  = queue_r[rd_ptr_r].last;

  // Configuration and packing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= ftc_pkg::DIR_ENCODE;
      field_type_r <= ftc_pkg::FT_RAW;
      state_r      <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == ftc_pkg::CFG_DIRECTION) direction_r <= cfg_data[0];
      else                                     field_type_r <= cfg_data;
      state_r <= '0;
    end else if (advance) begin
      state_r <= step.state_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (advance) begin
        wr_ptr_r <= wr_ptr_r + step.count;
        count_r  <= after_pop + {1'b0, step.count};
      end else begin
        count_r  <= after_pop;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
    end
  end

  // Result queue storage; the final result of a last request carries the flag
  always_ff @(posedge clk) begin
    if (advance && step.count != 2'd0) begin
      queue_r[wr_ptr_r].data <= step.res0;
      queue_r[wr_ptr_r].last <= s1_last_r & (step.count == 2'd1);
      if (step.count == 2'd2) begin
        queue_r[wr_ptr_r + 2'd1].data <= step.res1;
        queue_r[wr_ptr_r + 2'd1].last <= s1_last_r;
      end
    end
  end

endmodule
`default_nettype wire
